// ----- sv/assert_macros.svh -----
// assertion macros shared by the classifier rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define MRLC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define MRLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/mrlc_pkg.sv -----
// constants, prefix tables and shared types of the modem reply line classifier
`default_nettype none

package mrlc_pkg;

   localparam int NUM_PREFIXES   = 6;
   localparam int FAX_PREFIX     = 5;
   localparam int PREFIX_WIDTH   = 88;

   localparam logic [3:0] FAX_PREFIX_LEN = 4'd6;
   localparam logic [3:0] POS_MAX        = 4'd15;
   localparam logic [30:0] MAG_MAX       = 31'h7fff_ffff;

   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_TAB     = 8'd9;
   localparam logic [7:0] CHAR_VTAB    = 8'd11;
   localparam logic [7:0] CHAR_FF      = 8'd12;
   localparam logic [7:0] CHAR_CR      = 8'd13;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] CHAR_PLUS    = 8'd43;
   localparam logic [7:0] CHAR_MINUS   = 8'd45;
   localparam logic [7:0] CHAR_ZERO    = 8'd48;
   localparam logic [7:0] CHAR_NINE    = 8'd57;

   localparam logic [2:0] CODE_OK          = 3'd0;
   localparam logic [2:0] CODE_CONNECT     = 3'd1;
   localparam logic [2:0] CODE_NO_CARRIER  = 3'd2;
   localparam logic [2:0] CODE_ERROR       = 3'd3;
   localparam logic [2:0] CODE_NO_DIALTONE = 3'd4;
   localparam logic [2:0] CODE_FAX_HANGUP  = 3'd5;

   // right-justified text, first character in the highest used byte
   localparam logic [PREFIX_WIDTH-1:0] PREFIX_TEXT [NUM_PREFIXES] = '{
      PREFIX_WIDTH'("OK"),
      PREFIX_WIDTH'("CONNECT"),
      PREFIX_WIDTH'("NO CARRIER"),
      PREFIX_WIDTH'("ERROR"),
      PREFIX_WIDTH'("NO DIALTONE"),
      PREFIX_WIDTH'("+FHNG:")
   };

   localparam logic [3:0] PREFIX_LEN [NUM_PREFIXES] = '{
      4'd2, 4'd7, 4'd10, 4'd5, 4'd11, 4'd6
   };

   typedef struct packed {
      logic              valid;
      logic [2:0]        reply_code;
      logic signed [31:0] hangup_status;
   } result_type;

   function automatic logic [7:0] prefix_char(input logic [PREFIX_WIDTH-1:0] text,
                                              input logic [3:0] len,
                                              input logic [3:0] pos);
      logic [3:0] ofs;
      ofs = len - 4'd1 - pos;
      return text[{ofs, 3'b000} +: 8];
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VTAB) ||
             (c == CHAR_FF) || (c == CHAR_CR);
   endfunction

endpackage

`default_nettype wire

// ----- sv/mrlc_line_parser.sv -----
// per-line prefix matching and hang-up status accumulation
`default_nettype none
`include "assert_macros.svh"

module mrlc_line_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic [7:0]        rx_byte,
   output mrlc_pkg::result_type   result
);

   typedef enum logic [3:0] {
      PH_BLANK = 4'b0001,
      PH_SIGN  = 4'b0010,
      PH_DIGIT = 4'b0100,
      PH_DONE  = 4'b1000
   } phase_type;

   logic [3:0]  pos_ff, pos_in;
   logic [5:0]  cand_ff, cand_in;
   phase_type   phase_ff, phase_in;
   logic        neg_ff, neg_in;
   logic [30:0] mag_ff, mag_in;

   logic        is_nl;
   logic        is_digit;
   logic        is_sign;
   logic        num_active;
   logic        hit;
   logic [2:0]  hit_code;
   logic [34:0] mag_x10;
   logic [30:0] mag_acc;
   logic [31:0] mag_ext;

   assign is_nl    = (rx_byte == mrlc_pkg::CHAR_NEWLINE);
   assign is_digit = (rx_byte >= mrlc_pkg::CHAR_ZERO) && (rx_byte <= mrlc_pkg::CHAR_NINE);
   assign is_sign  = (rx_byte == mrlc_pkg::CHAR_PLUS) || (rx_byte == mrlc_pkg::CHAR_MINUS);
   assign num_active = (pos_ff >= mrlc_pkg::FAX_PREFIX_LEN) && cand_ff[mrlc_pkg::FAX_PREFIX];

   // magnitude times ten plus digit, saturated
   assign mag_x10 = ({4'b0, mag_ff} << 3) + ({4'b0, mag_ff} << 1) +
                    {31'b0, 4'(rx_byte - mrlc_pkg::CHAR_ZERO)};
   assign mag_acc = (mag_x10 > {4'b0, mrlc_pkg::MAG_MAX}) ? mrlc_pkg::MAG_MAX
                                                          : mag_x10[30:0];
   assign mag_ext = {1'b0, mag_ff};

   // lowest matching prefix index wins
   always_comb begin
      hit      = 1'b0;
      hit_code = mrlc_pkg::CODE_OK;
      for (int i = mrlc_pkg::NUM_PREFIXES - 1; i >= 0; i--) begin
         if (cand_ff[i] && (pos_ff >= mrlc_pkg::PREFIX_LEN[i])) begin
            hit      = 1'b1;
            hit_code = 3'(i);
         end
      end
   end

   always_comb begin
      result.valid         = is_nl && hit;
      result.reply_code    = hit_code;
      result.hangup_status = 32'sd0;
      if (hit_code == mrlc_pkg::CODE_FAX_HANGUP) begin
         result.hangup_status = neg_ff ? $signed(32'd0 - mag_ext) : $signed(mag_ext);
      end
   end

   always_comb begin
      cand_in  = cand_ff;
      phase_in = phase_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      pos_in   = (pos_ff < mrlc_pkg::POS_MAX) ? pos_ff + 4'd1 : pos_ff;
      for (int i = 0; i < mrlc_pkg::NUM_PREFIXES; i++) begin
         if ((pos_ff < mrlc_pkg::PREFIX_LEN[i]) &&
             (rx_byte != mrlc_pkg::prefix_char(mrlc_pkg::PREFIX_TEXT[i],
                                               mrlc_pkg::PREFIX_LEN[i], pos_ff))) begin
            cand_in[i] = 1'b0;
         end
      end
      if (num_active) begin
         case (phase_ff)
            PH_BLANK: begin
               if (mrlc_pkg::is_blank(rx_byte)) begin
                  phase_in = PH_BLANK;
               end else if (is_sign) begin
                  neg_in   = (rx_byte == mrlc_pkg::CHAR_MINUS);
                  phase_in = PH_SIGN;
               end else if (is_digit) begin
                  mag_in   = mag_acc;
                  phase_in = PH_DIGIT;
               end else begin
                  phase_in = PH_DONE;
               end
            end
            PH_SIGN, PH_DIGIT: begin
               if (is_digit) begin
                  mag_in   = mag_acc;
                  phase_in = PH_DIGIT;
               end else begin
                  phase_in = PH_DONE;
               end
            end
            PH_DONE: begin
               phase_in = PH_DONE;
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
      end
      // newline starts a fresh line
      if (is_nl) begin
         pos_in   = 4'd0;
         cand_in  = '1;
         phase_in = PH_BLANK;
         neg_in   = 1'b0;
         mag_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 4'd0;
         cand_ff  <= '1;
         phase_ff <= PH_BLANK;
         neg_ff   <= 1'b0;
         mag_ff   <= '0;
      end else if (en) begin
         pos_ff   <= pos_in;
         cand_ff  <= cand_in;
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         mag_ff   <= mag_in;
      end
   end

   `MRLC_ASSERT_IMPL(a_carrier_dialtone_exclusive, clock, reset, pos_ff >= 4'd4, !(cand_ff[mrlc_pkg::CODE_NO_CARRIER] && cand_ff[mrlc_pkg::CODE_NO_DIALTONE]), "no carrier and no dialtone both live past their split")
   `MRLC_ASSERT_IMPL(a_number_only_after_fax, clock, reset, phase_ff != PH_BLANK || neg_ff, cand_ff[mrlc_pkg::FAX_PREFIX] && pos_ff >= 4'd7, "number parsing started outside a fax hangup line")

endmodule

`default_nettype wire

// ----- sv/modem_reply_line_classifier.sv -----
// Modem reply line classifier, top level.
// The req channel carries one received modem byte per beat in req_tdata[7:0].
// A newline byte (10) closes the line; if the start of the line matches
// OK, CONNECT, NO CARRIER, ERROR, NO DIALTONE or +FHNG:, one beat leaves on
// the rsp channel with the reply code and, for +FHNG:, the signed decimal
// hang-up status that follows it (zero for every other reply).
// Lines that are empty or match nothing produce no beat.
// A byte is registered in the input register on acceptance and its result
// in the output register. One byte is taken every cycle unless a newline
// result waits on a stalled receiver; the limit is the single line-state
// update (prefix flags and the times-ten accumulator) done per byte.
// When the receiver stalls, the pending result holds in the output register
// and bytes that produce no result still flow; a second newline result
// waits in the input register until the output register frees up.
// Synchronous reset empties both registers and returns the line state to
// the start of a line.
`default_nettype none
`include "assert_macros.svh"

module modem_reply_line_classifier (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // [2:0] reply_code, [34:3] hangup_status, [39:35] zero
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff, in_byte_in;
   logic                 out_valid_ff, out_valid_in;
   logic [2:0]           out_code_ff, out_code_in;
   logic signed [31:0]   out_status_ff, out_status_in;

   logic                 out_free;
   logic                 advance;
   mrlc_pkg::result_type result;

   mrlc_line_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .en      (advance),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!result.valid || out_free);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_byte_in    = in_byte_ff;
      out_valid_in  = out_valid_ff;
      out_code_in   = out_code_ff;
      out_status_in = out_status_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance && result.valid) begin
         out_valid_in  = 1'b1;
         out_code_in   = result.reply_code;
         out_status_in = result.hangup_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      out_code_ff   <= out_code_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_status_ff, out_code_ff};

   `MRLC_ASSERT_IMPL(a_status_only_for_fax, clock, reset, out_valid_ff && out_code_ff != mrlc_pkg::CODE_FAX_HANGUP, out_status_ff == 32'sd0, "hangup status nonzero on a non-fax reply")
   `MRLC_ASSERT_NEXT(a_input_held_while_blocked, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_byte_ff), "blocked byte lost from the input register")

endmodule

`default_nettype wire

// ----- verif/modem_reply_line_classifier_test.sv -----
// self-checking testbench for the modem reply line classifier
module modem_reply_line_classifier_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_REPLIES   = 6;
   localparam int FAX_WORD      = 5;
   localparam int FAX_WORD_LEN  = 6;
   localparam int LINE_POS_TOP  = 15;
   localparam int SETTLE_CYCLES = 10;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int HOLD_CYCLES   = 300;

   localparam logic [7:0] NL_CHAR    = 8'd10;
   localparam logic [7:0] TAB_CHAR   = 8'd9;
   localparam logic [7:0] VT_CHAR    = 8'd11;
   localparam logic [7:0] FF_CHAR    = 8'd12;
   localparam logic [7:0] CR_CHAR    = 8'd13;
   localparam logic [7:0] SP_CHAR    = 8'd32;
   localparam logic [7:0] PLUS_CHAR  = 8'd43;
   localparam logic [7:0] MINUS_CHAR = 8'd45;
   localparam logic [7:0] ZERO_CHAR  = 8'd48;
   localparam logic [7:0] NINE_CHAR  = 8'd57;
   localparam logic [7:0] NUL_CHAR   = 8'd0;
   localparam logic [30:0] STATUS_TOP = 31'h7fff_ffff;

   localparam logic [7:0] BLANK_CHARS [5] = '{SP_CHAR, TAB_CHAR, VT_CHAR, FF_CHAR, CR_CHAR};
   localparam logic [2:0] REPLY_CODES [NUM_REPLIES] = '{
      mrlc_pkg::CODE_OK, mrlc_pkg::CODE_CONNECT, mrlc_pkg::CODE_NO_CARRIER,
      mrlc_pkg::CODE_ERROR, mrlc_pkg::CODE_NO_DIALTONE, mrlc_pkg::CODE_FAX_HANGUP
   };

   typedef enum logic [1:0] {SKIP_BLANKS, AFTER_SIGN, IN_DIGITS, NUMBER_DONE} status_phase_type;

   typedef struct packed {
      logic [2:0]         reply_code;
      logic signed [31:0] hangup_status;
   } reply_type;

   string reply_word [NUM_REPLIES] = '{
      "OK", "CONNECT", "NO CARRIER", "ERROR", "NO DIALTONE", "+FHNG:"
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;    // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // [2:0] reply_code, [34:3] hangup_status, [39:35] zero

   // line state of the predictor
   logic [3:0]       line_len;
   logic [5:0]       word_alive;
   status_phase_type status_phase;
   logic             status_neg;
   logic [30:0]      status_mag;

   reply_type expected_replies [$];
   reply_type oldest_reply;
   int     failures = 0;
   int     bytes_accepted = 0;
   int     tx_idle_pct = 0;
   int     rx_stall_pct = 0;
   int     rx_hold_cycles = 0;

   modem_reply_line_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2ms;
      $display("Mismatches found");
      $finish;
   end

   function automatic void start_new_line();
      line_len     = 4'd0;
      word_alive   = 6'h3f;
      status_phase = SKIP_BLANKS;
      status_neg   = 1'b0;
      status_mag   = 31'd0;
   endfunction

   function automatic void parse_status_char(input logic [7:0] c);
      logic [63:0] grown;
      logic        blank;
      blank = (c == SP_CHAR) || (c == TAB_CHAR) || (c == VT_CHAR) ||
              (c == FF_CHAR) || (c == CR_CHAR);
      if (status_phase == SKIP_BLANKS && blank) begin
         return;
      end
      if (status_phase == SKIP_BLANKS && (c == PLUS_CHAR || c == MINUS_CHAR)) begin
         status_neg   = (c == MINUS_CHAR);
         status_phase = AFTER_SIGN;
      end else if (status_phase != NUMBER_DONE && c >= ZERO_CHAR && c <= NINE_CHAR) begin
         grown        = 64'(status_mag) * 64'd10 + 64'(c - ZERO_CHAR);
         status_mag   = (grown > 64'(STATUS_TOP)) ? STATUS_TOP : grown[30:0];
         status_phase = IN_DIGITS;
      end else begin
         status_phase = NUMBER_DONE;
      end
   endfunction

   // classify one received byte, queueing the reply that a closed line yields
   function automatic void classify_byte(input logic [7:0] c);
      reply_type r;
      logic   found;
      int     i;
      found = 1'b0;
      if (c == NL_CHAR) begin
         for (i = 0; i < NUM_REPLIES; i++) begin
            if (!found && word_alive[i] && int'(line_len) >= reply_word[i].len()) begin
               found           = 1'b1;
               r.reply_code    = REPLY_CODES[i];
               r.hangup_status = 32'sd0;
               if (i == FAX_WORD) begin
                  r.hangup_status = {1'b0, status_mag};
                  if (status_neg) r.hangup_status = -r.hangup_status;
               end
            end
         end
         if (found) expected_replies.push_back(r);
         start_new_line();
      end else begin
         for (i = 0; i < NUM_REPLIES; i++) begin
            if (int'(line_len) < reply_word[i].len() && c != reply_word[i][line_len]) begin
               word_alive[i] = 1'b0;
            end
         end
         if (int'(line_len) >= FAX_WORD_LEN && word_alive[FAX_WORD]) parse_status_char(c);
         if (int'(line_len) < LINE_POS_TOP) line_len = line_len + 4'd1;
      end
   endfunction

   task automatic send_byte(input logic [7:0] c);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = c;
      do @(posedge clock); while (!req_tready);
      classify_byte(c);
      bytes_accepted++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic wait_for_replies();
      int n;
      n = 0;
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_replies.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver: random stalls, or a counted hold-off when one is requested
   always @(negedge clock) begin
      if (rx_hold_cycles > 0) begin
         rsp_tready = 1'b0;
         rx_hold_cycles--;
      end else begin
         rsp_tready = ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_replies.size() == 0) begin
            $error("unexpected beat: reply_code %0d hangup_status %0d",
                   rsp_tdata[2:0], $signed(rsp_tdata[34:3]));
            failures++;
         end else begin
            oldest_reply = expected_replies.pop_front();
            if (rsp_tdata[2:0] != oldest_reply.reply_code) begin
               $error("reply_code: expected %0d, actual %0d",
                      oldest_reply.reply_code, rsp_tdata[2:0]);
               failures++;
            end
            if ($signed(rsp_tdata[34:3]) != oldest_reply.hangup_status) begin
               $error("hangup_status: expected %0d, actual %0d",
                      oldest_reply.hangup_status, $signed(rsp_tdata[34:3]));
               failures++;
            end
         end
      end
   end

   task automatic test_reply_words();
      send_text("OK\n");
      send_text("CONNECT 9600\n");
      send_text("NO CARRIER\n");
      send_text("ERROR\n");
      send_text("NO DIALTONE\n");
      send_text("+FHNG:\n");
      send_text("OKAY\n");
      send_text("\n");
   endtask

   task automatic test_short_lines();
      send_text("O\n");
      send_text("CONNEC\n");
      send_text("NO CARRIE\n");
      send_text("+FHNG\n");
      send_text("HELLO\n");
   endtask

   task automatic test_status_parsing();
      send_text("+FHNG: \t\v\f\015 17\n");
      send_text("+FHNG:-\n");
      send_text("+FHNG:+ 5\n");
      send_text("+FHNG:2147483647\n");
      send_text("+FHNG:-2147483648\n");
      send_text("+FHNG:99999999999999\n");
      send_text("+FHNG:12abc34\n");
   endtask

   task automatic test_odd_bytes();
      int i;
      send_byte(NUL_CHAR);
      send_text("OK\n");
      send_text("+FHNG:");
      send_byte(NUL_CHAR);
      send_text("5\n");
      send_text("OK");
      send_byte(NUL_CHAR);
      send_byte(8'hff);
      send_byte(8'h80);
      send_byte(NL_CHAR);
      send_text("ERROR");
      for (i = 0; i < 30; i++) send_byte(8'h78);
      send_byte(NL_CHAR);
      send_text("+FHNG:");
      for (i = 0; i < 20; i++) send_byte(SP_CHAR);
      send_text("-42\n");
   endtask

   task automatic send_random_line();
      logic [7:0] line_q [$];
      logic [7:0] c;
      string      text;
      int         kind, word, n, i;
      kind = $urandom_range(99);
      if (kind < 75) begin
         word = $urandom_range(NUM_REPLIES - 1);
         text = reply_word[word];
         for (i = 0; i < text.len(); i++) line_q.push_back(text[i]);
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, line_q.size())) void'(line_q.pop_back());
         end else if ($urandom_range(9) == 0) begin
            line_q[$urandom_range(line_q.size() - 1)] = 8'($urandom_range(32, 126));
         end
         if (word == FAX_WORD && $urandom_range(9) != 0) begin
            repeat ($urandom_range(3)) line_q.push_back(BLANK_CHARS[$urandom_range(4)]);
            case ($urandom_range(3))
               0: line_q.push_back(PLUS_CHAR);
               1: line_q.push_back(MINUS_CHAR);
               default: ;
            endcase
            n = ($urandom_range(9) == 0) ? $urandom_range(10, 14) : $urandom_range(9);
            repeat (n) line_q.push_back(8'(ZERO_CHAR + $urandom_range(9)));
            repeat ($urandom_range(2)) begin
               c = 8'($urandom_range(255));
               line_q.push_back((c == NL_CHAR) ? SP_CHAR : c);
            end
         end else begin
            repeat ($urandom_range(5)) line_q.push_back(8'($urandom_range(32, 126)));
         end
      end else if (kind < 92) begin
         repeat ($urandom_range(1, 20)) line_q.push_back(8'($urandom_range(255)));
      end else if (kind < 96) begin
         line_q.push_back(CR_CHAR);
      end
      line_q.push_back(NL_CHAR);
      foreach (line_q[i]) send_byte(line_q[i]);
   endtask

   task automatic test_random_lines(input int tx_pct, input int rx_pct, input int n_bytes);
      int stop_at;
      tx_idle_pct  = tx_pct;
      rx_stall_pct = rx_pct;
      stop_at      = bytes_accepted + n_bytes;
      while (bytes_accepted < stop_at) send_random_line();
   endtask

   task automatic test_output_backpressure();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      @(negedge clock);
      req_tvalid     = 1'b0;
      rx_hold_cycles = HOLD_CYCLES;
      repeat (40) send_text("OK\n");
      repeat (10) send_text("+FHNG:-7\n");
   endtask

   task automatic test_pause_until_drained();
      tx_idle_pct  = 0;
      rx_stall_pct = 30;
      repeat (5) send_text("NO DIALTONE\n");
      wait_for_replies();
      repeat (5) send_text("+FHNG: 3\n");
   endtask

   initial begin
      start_new_line();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reply_words();
      test_short_lines();
      test_status_parsing();
      test_odd_bytes();
      test_output_backpressure();
      test_pause_until_drained();
      test_random_lines(0, 0, 100);
      test_random_lines(48, 0, 100);
      test_random_lines(0, 48, 100);
      test_random_lines(8, 8, 100);

      rx_stall_pct = 0;
      wait_for_replies();
      while (expected_replies.size() != 0) begin
         oldest_reply = expected_replies.pop_front();
         $error("missing beat: reply_code %0d hangup_status %0d",
                oldest_reply.reply_code, oldest_reply.hangup_status);
         failures++;
      end
      if (failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
